// ===== design/banded_all_pairs_closest_days_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the banded closest-days block
// Shared clocking and reset for the concurrent checks.
// ---------------------------------------------------------------------------
`ifndef BANDED_ALL_PAIRS_CLOSEST_DAYS_DEFINES_SVH
`define BANDED_ALL_PAIRS_CLOSEST_DAYS_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BAPCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check an implication on every clock edge outside reset.
`define BAPCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/bapcd_pkg.sv =====
// ---------------------------------------------------------------------------
// bapcd_pkg
// Constants and types for the banded closest-days block.
// ---------------------------------------------------------------------------
package bapcd_pkg;
    localparam int MAX_DAYS    = 64;
    localparam int PRICE_BITS  = 16;
    localparam int IDX_W       = $clog2(MAX_DAYS);
    localparam int CNT_W       = $clog2(MAX_DAYS + 1);
    localparam int DAY_W       = 7;
    localparam int LIM_W       = 5;
    localparam int OUT_W       = 32;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd5;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_WAIT
    } t_state;

    typedef logic [PRICE_BITS-1:0] t_price;
endpackage

// ===== design/bapcd_cell.sv =====
// ---------------------------------------------------------------------------
// bapcd_cell
// One price cell of the ring: loads a price, or takes its neighbor's value.
// ---------------------------------------------------------------------------
module bapcd_cell (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic               i_rotate,
    input  bapcd_pkg::t_price  i_price,
    input  bapcd_pkg::t_price  i_next,
    output bapcd_pkg::t_price  o_value
);
    import bapcd_pkg::*;

    t_price r_value;
    t_price n_value;

    always_comb begin
        n_value = r_value;
        if (i_load) begin
            n_value = i_price;
        end else if (i_rotate) begin
            n_value = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
endmodule

// ===== design/banded_all_pairs_closest_days.sv =====
// ---------------------------------------------------------------------------
// banded_all_pairs_closest_days
// Loads a price series and reports the closest pair of days.
// ---------------------------------------------------------------------------
// Input stream: one price per request in s_axis_tdata, s_axis_tlast closes
// the series. Prices are taken back to back while loading. Up to 64
// prices are kept; further ones are dropped and flagged in the result.
// On the closing request the block scans a ring of 64 price cells. For each
// earlier day i the ring turns a full round plus one cell, bringing every
// later day to the head cell where it meets the latched price of day i;
// pairs within day_limit are compared with the best difference so far. With
// nonnegative weights the closest path pair is always a direct banded edge
// (equal-price chains reduce to a direct neighbor), so this gives the
// shortest-path result. Output stream: one result request per series, held
// in an output register. New prices are taken while a result waits; a
// finished scan waits for the output register to drain when the receiver
// stalls. Reset clears the day count, overflow flag, output valid and state
// and sets day_limit to 5. day_limit is written through i_cfg_we /
// i_cfg_wdata by the user only while idle; the block does not enforce this.
// ---------------------------------------------------------------------------
`include "banded_all_pairs_closest_days_defines.svh"

module banded_all_pairs_closest_days (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bapcd_pkg::LIM_W-1:0]  i_cfg_wdata,   // day_limit
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [15:0]                  s_axis_tdata,  // price[15:0]
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // first_day[6:0], second_day[13:7], min_change[29:14], found[30],
    // overflowed[31]
    output logic [bapcd_pkg::OUT_W-1:0]  m_axis_tdata
);
    import bapcd_pkg::*;

    t_state             r_state, n_state;
    logic [LIM_W-1:0]   r_limit;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [IDX_W-1:0]   r_i, n_i;
    logic [CNT_W-1:0]   r_t, n_t;
    t_price             r_ref, n_ref;
    t_price             r_best, n_best;
    logic [DAY_W-1:0]   r_bi, n_bi, r_bj, n_bj;
    logic               r_have, n_have;
    logic               r_out_valid, n_out_valid;
    logic [OUT_W-1:0]   r_out, n_out;

    logic               in_acc;
    logic               rotate;
    t_price             cell_val [MAX_DAYS];
    t_price             head;
    t_price             diff;
    logic [CNT_W:0]     j_sum;
    logic               pair_ok;

    // Ring of price cells; cell k takes cell k+1, the last wraps to cell 0.
    for (genvar k = 0; k < MAX_DAYS; k++) begin : g_cell
        logic ld;
        assign ld = in_acc && (r_count == CNT_W'(k));
        bapcd_cell u_cell (
            .i_clk    (i_clk),
            .i_load   (ld),
            .i_rotate (rotate),
            .i_price  (s_axis_tdata[PRICE_BITS-1:0]),
            .i_next   (cell_val[(k + 1) % MAX_DAYS]),
            .o_value  (cell_val[k])
        );
    end

    assign head    = cell_val[0];
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign rotate  = (r_state == ST_SCAN);
    assign diff    = (head > r_ref) ? head - r_ref : r_ref - head;
    assign j_sum   = (CNT_W+1)'(r_i) + (CNT_W+1)'(r_t);
    // j = i + t is a direct neighbor inside the series
    assign pair_ok = (r_t != '0) && (r_t <= CNT_W'(r_limit)) && (j_sum < (CNT_W+1)'(r_n));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_n         = r_n;
        n_i         = r_i;
        n_t         = r_t;
        n_ref       = r_ref;
        n_best      = r_best;
        n_bi        = r_bi;
        n_bj        = r_bj;
        n_have      = r_have;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out       = r_out;
        s_axis_tready = (r_state == ST_LOAD);
        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (r_count == CNT_W'(MAX_DAYS)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_n     = n_count;
                        n_i     = '0;
                        n_t     = '0;
                        n_have  = 1'b0;
                        n_best  = '0;
                        n_bi    = '0;
                        n_bj    = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_t == '0) begin
                    n_ref = head;
                    if ((CNT_W'(r_i) + 1'b1) >= r_n) begin
                        n_state = ST_WAIT;
                    end else begin
                        n_t = r_t + 1'b1;
                    end
                end else begin
                    if (pair_ok && (!r_have || diff < r_best)) begin
                        n_have = 1'b1;
                        n_best = diff;
                        n_bi   = DAY_W'(r_i) + 1'b1;
                        n_bj   = DAY_W'(j_sum) + 1'b1;
                    end
                    if (r_t == CNT_W'(MAX_DAYS)) begin
                        n_t = '0;
                        n_i = r_i + 1'b1;
                    end else begin
                        n_t = r_t + 1'b1;
                    end
                end
            end
            ST_WAIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out       = {r_ovf, r_have, 16'(r_best), r_bj, r_bi};
                    n_count     = '0;
                    n_ovf       = 1'b0;
                    n_state     = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_limit     <= LIMIT_RESET;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_i    <= n_i;
        r_t    <= n_t;
        r_ref  <= n_ref;
        r_best <= n_best;
        r_bi   <= n_bi;
        r_bj   <= n_bj;
        r_have <= n_have;
        r_out  <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    `BAPCD_ASSERT(a_count_range, (r_count <= CNT_W'(MAX_DAYS)), "day count beyond capacity")
    `BAPCD_ASSERT_IMP(a_no_load_in_scan, (r_state != ST_LOAD), !s_axis_tready, "input taken while busy")
    `BAPCD_ASSERT_IMP(a_pair_order, (r_state == ST_SCAN) && r_have, (r_bi < r_bj), "pair out of order")
    `BAPCD_ASSERT_IMP(a_ovf_full, r_ovf, (r_count == CNT_W'(MAX_DAYS)), "overflow without full store")
endmodule

// ===== tb/banded_all_pairs_closest_days_tb.sv =====
// ---------------------------------------------------------------------------
// banded_all_pairs_closest_days_tb
// Streams price series into the closest-days block across several day_limit
// settings. An all-pairs shortest path solver in the bench predicts each
// result, and every result request is checked field by field against it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module banded_all_pairs_closest_days_tb;
    import bapcd_pkg::*;

    typedef struct packed {
        logic [15:0] price;
        logic        last;
    } price_req_t;

    typedef struct packed {
        logic [6:0]  first_day;
        logic [6:0]  second_day;
        logic [15:0] min_change;
        logic        found;
        logic        overflowed;
    } closest_pair_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [LIM_W-1:0]    i_cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata;   // price[15:0]
    logic                s_axis_tlast;   // closes the series
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // first_day[6:0], second_day[13:7], min_change[29:14], found[30],
    // overflowed[31]
    logic [OUT_W-1:0]    m_axis_tdata;

    banded_all_pairs_closest_days i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Requests waiting for the driver, and pair results still owed by the block.
    price_req_t    pending_prices[$];
    closest_pair_t owed_pairs[$];

    // Bench copy of block state.
    logic [15:0]   day_price[MAX_DAYS];
    int unsigned   path_len[MAX_DAYS][MAX_DAYS];
    bit            path_ok[MAX_DAYS][MAX_DAYS];
    int            held_days;
    bit            dropped_any;
    int            band_limit;

    int  mismatches;
    int  series_closed;
    int  pairs_checked;
    int  overflow_series;
    int  prices_sent;
    int  src_gap;
    int  snk_gap;
    bit  bursty;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // All-pairs shortest path over the banded edge set; unreachable entries
    // keep path_ok clear and never feed a relaxation.
    task automatic solve_paths(input int n);
        int sep;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                sep = (i > j) ? i - j : j - i;
                if (i == j) begin
                    path_len[i][j] = 0;
                    path_ok[i][j]  = 1'b1;
                end else if (sep <= band_limit) begin
                    path_len[i][j] = (day_price[i] > day_price[j]) ?
                                     day_price[i] - day_price[j] :
                                     day_price[j] - day_price[i];
                    path_ok[i][j]  = 1'b1;
                end else begin
                    path_len[i][j] = 0;
                    path_ok[i][j]  = 1'b0;
                end
            end
        end
        for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                    if (path_ok[i][k] && path_ok[k][j] &&
                        (!path_ok[i][j] || path_len[i][k] + path_len[k][j] < path_len[i][j]))
                    begin
                        path_len[i][j] = path_len[i][k] + path_len[k][j];
                        path_ok[i][j]  = 1'b1;
                    end
    endtask

    // Accepted price request: store it, and on the closing one owe a result.
    task automatic take_price(input logic [15:0] p, input logic lst);
        closest_pair_t r;
        int unsigned   best;
        bit            have;
        int            n;
        if (held_days < MAX_DAYS) begin
            day_price[held_days] = p;
            held_days++;
        end else begin
            dropped_any = 1'b1;
        end
        if (!lst) return;
        n    = held_days;
        have = 1'b0;
        best = 0;
        r    = '0;
        if (n >= 2) begin
            solve_paths(n);
            // strict less-than keeps the first pair in row-major order
            for (int i = 0; i < n; i++)
                for (int j = i + 1; j < n; j++)
                    if (path_ok[i][j] && (!have || path_len[i][j] < best)) begin
                        best         = path_len[i][j];
                        r.first_day  = 7'(i + 1);
                        r.second_day = 7'(j + 1);
                        have         = 1'b1;
                    end
        end
        r.min_change = have ? 16'(best) : 16'd0;
        r.found      = have;
        r.overflowed = dropped_any;
        if (dropped_any) overflow_series++;
        owed_pairs = {owed_pairs, r};
        series_closed++;
        held_days   = 0;
        dropped_any = 1'b0;
    endtask

    task automatic report(input string field, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $time, field, got, want);
        mismatches++;
    endtask

    // Driver: one request per handshake, random hold-offs while bursty.
    always @(posedge i_clk) begin
        price_req_t nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                take_price(s_axis_tdata, s_axis_tlast);
                prices_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_prices.size() > 0) begin
                    nxt = pending_prices.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.price;
                    s_axis_tlast  <= nxt.last;
                    if (bursty && $urandom_range(0, 7) == 0)
                        src_gap = $urandom_range(1, 11);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result request against the oldest owed pair.
    always @(posedge i_clk) begin
        closest_pair_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (owed_pairs.size() == 0) begin
                    report("result with nothing owed", int'(m_axis_tdata), 0);
                end else begin
                    want = owed_pairs.pop_front();
                    pairs_checked++;
                    if (m_axis_tdata[6:0] !== want.first_day)
                        report("first_day", m_axis_tdata[6:0], want.first_day);
                    if (m_axis_tdata[13:7] !== want.second_day)
                        report("second_day", m_axis_tdata[13:7], want.second_day);
                    if (m_axis_tdata[29:14] !== want.min_change)
                        report("min_change", m_axis_tdata[29:14], want.min_change);
                    if (m_axis_tdata[30] !== want.found)
                        report("found", m_axis_tdata[30], want.found);
                    if (m_axis_tdata[31] !== want.overflowed)
                        report("overflowed", m_axis_tdata[31], want.overflowed);
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (bursty && $urandom_range(0, 7) == 0)
                    snk_gap = $urandom_range(1, 11);
            end
        end
    end

    function automatic logic [15:0] pick_price(input int style);
        case (style)
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(1000, 1007));   // near ties
            2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(0, 3) * 16'h5555);
        endcase
    endfunction

    task automatic queue_series(input int n, input int style);
        price_req_t r;
        for (int d = 0; d < n; d++) begin
            r.price = pick_price(style);
            r.last  = (d == n - 1);
            pending_prices = {pending_prices, r};
        end
    endtask

    task automatic queue_price(input logic [15:0] p, input logic lst);
        price_req_t r;
        r.price = p;
        r.last  = lst;
        pending_prices = {pending_prices, r};
    endtask

    // Random series: mostly short, now and then a long or overflowing one.
    task automatic queue_random(input int quota);
        int n;
        int queued;
        queued = 0;
        while (queued < quota) begin
            n = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 70) :
                                               $urandom_range(1, 14);
            queue_series(n, $urandom_range(0, 3));
            queued += n;
        end
    endtask

    // Let the block drain, then a quiet spell before touching the register.
    task automatic drain_block();
        while (pending_prices.size() > 0 || s_axis_tvalid || owed_pairs.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [LIM_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        band_limit  = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [LIM_W-1:0] limits[6];
        limits = '{5'd2, 5'd30, 5'd0, 5'd31, 5'd1, 5'd5};

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        held_days     = 0;
        dropped_any   = 1'b0;
        band_limit    = LIMIT_RESET;
        mismatches    = 0;
        series_closed = 0;
        pairs_checked = 0;
        overflow_series = 0;
        prices_sent   = 0;
        src_gap       = 0;
        snk_gap       = 0;
        bursty        = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, at the reset limit of 5: one day alone, extreme prices,
        // a tie that must report the earliest pair, prices on multiples of 16'h5555.
        queue_price(16'h1234, 1'b1);
        queue_price(16'h0000, 1'b0);
        queue_price(16'hFFFF, 1'b1);
        queue_price(16'hFFFF, 1'b0);
        queue_price(16'h0000, 1'b0);
        queue_price(16'hFFFF, 1'b1);
        queue_price(16'd10, 1'b0);
        queue_price(16'd20, 1'b0);
        queue_price(16'd30, 1'b0);
        queue_price(16'd25, 1'b0);
        queue_price(16'd15, 1'b1);
        queue_series(4, 3);
        queue_price(16'hAAAA, 1'b0);
        queue_price(16'h5555, 1'b1);
        queue_random(180);
        drain_block();

        // One phase per limit: small, large and extreme values, then the default.
        foreach (limits[p]) begin
            set_limit(limits[p]);
            repeat (2) @(posedge i_clk);
            // the no-edge limit also gets a nine-day series
            if (limits[p] == 5'd0) queue_series(9, 0);
            if (p == 5) begin
                bursty = 1'b0;
                src_gap = 0;
                snk_gap = 0;
            end
            queue_random(p == 5 ? 160 : 280);
            drain_block();
        end

        repeat (60) @(posedge i_clk);
        $display("%0d prices in %0d series (%0d overflowing), %0d results checked",
                 prices_sent, series_closed, overflow_series, pairs_checked);
        $display("day_limit settings 5, 2, 30, 0, 31, 1 and back to 5");
        if (mismatches == 0 && owed_pairs.size() == 0) begin
            $display("banded_all_pairs_closest_days: match");
        end else begin
            $display("banded_all_pairs_closest_days: mismatch");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("banded_all_pairs_closest_days: mismatch");
        $finish;
    end
endmodule
